// ===== hdl/uahw_pkg.sv =====
package uahw_pkg;

    // Field widths of the archive stream and of the records.
    localparam int DATA_W   = 8;
    localparam int SIZE_W   = 36;
    localparam int SKIP_W   = 7;
    localparam int CODE_W   = 2;
    localparam int MAX_W    = 16;
    localparam int OFFSET_W = 9;

    // Header layout, counted in bytes from the start of a 512-byte block.
    localparam logic [OFFSET_W-1:0] OFF_NAME_END = OFFSET_W'(100);
    localparam logic [OFFSET_W-1:0] OFF_SIZE_LO  = OFFSET_W'(124);
    localparam logic [OFFSET_W-1:0] OFF_SIZE_HI  = OFFSET_W'(135);
    localparam logic [OFFSET_W-1:0] OFF_TYPE     = OFFSET_W'(156);
    localparam logic [OFFSET_W-1:0] OFF_MAGIC_LO = OFFSET_W'(257);
    localparam logic [OFFSET_W-1:0] OFF_MAGIC_HI = OFFSET_W'(261);
    localparam logic [OFFSET_W-1:0] OFF_LAST     = OFFSET_W'(511);

    localparam logic [SKIP_W-1:0]  STRIP_MAX    = SKIP_W'(100);
    localparam logic [MAX_W-1:0]   MAX_DATA_RST = MAX_W'(256);

    // Characters that the header scan looks for.
    localparam logic [DATA_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [DATA_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [DATA_W-1:0] CHAR_DIR   = 8'h35;
    localparam logic [DATA_W-1:0] CHAR_FILE  = 8'h30;
    localparam logic [4:0]        OCTAL_HI5  = 5'b00110;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_STOP   = 2'd2
    } t_phase;

    typedef enum logic [CODE_W-1:0] {
        KIND_ENTRY = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [CODE_W-1:0] {
        ETYPE_OTHER = 2'd0,
        ETYPE_DIR   = 2'd1,
        ETYPE_FILE  = 2'd2
    } t_etype;

    // Expected magic character at a given position of "ustar".
    function automatic logic [DATA_W-1:0] magic_char(input logic [2:0] idx);
        logic [DATA_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/uahw_in_if.sv =====
interface uahw_in_if;
    logic                          valid;
    logic                          ready;
    logic [uahw_pkg::DATA_W-1:0]   data_in;
    logic                          last_in;

    modport source (output valid, output data_in, output last_in, input ready);
    modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

// ===== hdl/uahw_out_if.sv =====
interface uahw_out_if;
    logic                          valid;
    logic                          ready;
    logic [uahw_pkg::CODE_W-1:0]   kind;
    logic [uahw_pkg::CODE_W-1:0]   entry_type;
    logic [uahw_pkg::SIZE_W-1:0]   entry_size;
    logic [uahw_pkg::SKIP_W-1:0]   name_skip;
    logic                          data_kept;
    logic [uahw_pkg::DATA_W-1:0]   payload;
    logic                          end_of_file;

    modport source (output valid, output kind, output entry_type, output entry_size,
                    output name_skip, output data_kept, output payload,
                    output end_of_file, input ready);
    modport sink   (input valid, input kind, input entry_type, input entry_size,
                    input name_skip, input data_kept, input payload,
                    input end_of_file, output ready);
endinterface

// ===== hdl/ustar_archive_header_walker.sv =====
// Walks a tar archive presented one byte per word and reports each 512-byte
// ustar header as an entry record (or an end record when a header is not
// valid), then forwards the data bytes of regular files no larger than
// max_data. The block takes one byte every clock cycle: a byte is captured
// in an input register, processed by one pass of counter and flag logic, and
// its record, if any, lands in the output register when the byte is
// processed. A waiting record does not stop the next byte from entering the
// input register; the stream stalls only when both registers are full and
// the output is not taken. After the byte marked last_in the walker starts
// over from the header of a new archive; max_data keeps its value.
module ustar_archive_header_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [uahw_pkg::MAX_W-1:0]    i_cfg_wr_data,
    uahw_in_if.sink                       i_in,
    uahw_out_if.source                    o_out
);

    // Configuration register.
    logic [uahw_pkg::MAX_W-1:0] r_max_data;

    // Input register.
    logic                        r_in_valid;
    logic [uahw_pkg::DATA_W-1:0] r_data;
    logic                        r_last;

    // Walk state.
    uahw_pkg::t_phase              r_phase, n_phase;
    logic [uahw_pkg::OFFSET_W-1:0] r_off, n_off;
    logic [uahw_pkg::SIZE_W-1:0]   r_size, n_size;
    logic                          r_digits_done, n_digits_done;
    logic                          r_first_nz, n_first_nz;
    logic                          r_magic_ok, n_magic_ok;
    logic [uahw_pkg::DATA_W-1:0]   r_type, n_type;
    logic [uahw_pkg::SKIP_W-1:0]   r_strip, n_strip;
    logic                          r_stripping, n_stripping;
    logic [uahw_pkg::SIZE_W-1:0]   r_left, n_left;
    logic                          r_fwd, n_fwd;

    // Output register.
    logic                          r_out_valid;
    uahw_pkg::t_kind               r_kind, n_kind;
    uahw_pkg::t_etype              r_etype, n_etype;
    logic [uahw_pkg::SIZE_W-1:0]   r_esize, n_esize;
    logic [uahw_pkg::SKIP_W-1:0]   r_skip, n_skip;
    logic                          r_kept, n_kept;
    logic [uahw_pkg::DATA_W-1:0]   r_payload, n_payload;
    logic                          r_eof, n_eof;
    logic                          n_res;

    logic advance;
    logic proc;
    logic hdr_ok;
    logic hdr_end;
    logic data_done;

    logic                          strip_on;
    logic [uahw_pkg::SKIP_W-1:0]   strip_base;
    logic                          magic_base;
    logic [uahw_pkg::OFFSET_W-1:0] magic_idx;
    logic                          is_octal;
    logic                          size_fits;
    uahw_pkg::t_etype              etype;

    // Handshake: the output register moves when empty or taken.
    assign advance    = !r_out_valid || o_out.ready;
    assign proc       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign hdr_ok    = r_first_nz && r_magic_ok;
    assign hdr_end   = (r_phase == uahw_pkg::PH_HEADER) && (r_off == uahw_pkg::OFF_LAST);
    assign is_octal  = (r_data[7:3] == uahw_pkg::OCTAL_HI5);
    assign magic_idx = r_off - uahw_pkg::OFF_MAGIC_LO;
    assign size_fits = (r_size[uahw_pkg::SIZE_W-1:uahw_pkg::MAX_W] == '0)
                    && (r_size[uahw_pkg::MAX_W-1:0] <= r_max_data);

    // Type code from the stored type byte.
    always_comb begin
        if (r_type == uahw_pkg::CHAR_DIR) begin
            etype = uahw_pkg::ETYPE_DIR;
        end else if (r_type == uahw_pkg::CHAR_FILE) begin
            etype = uahw_pkg::ETYPE_FILE;
        end else begin
            etype = uahw_pkg::ETYPE_OTHER;
        end
    end

    // Next phase of the walk.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            uahw_pkg::PH_HEADER: begin
                if (r_off == uahw_pkg::OFF_LAST) begin
                    if (!hdr_ok) begin
                        n_phase = uahw_pkg::PH_STOP;
                    end else if (r_size != '0) begin
                        n_phase = uahw_pkg::PH_DATA;
                    end
                end
            end
            uahw_pkg::PH_DATA: begin
                if (data_done) begin
                    n_phase = uahw_pkg::PH_HEADER;
                end
            end
            uahw_pkg::PH_STOP: begin
                n_phase = uahw_pkg::PH_STOP;
            end
            default: begin
                n_phase = uahw_pkg::PH_HEADER;
            end
        endcase
    end

    // Header scan, data countdown and the record built from this byte.
    always_comb begin
        n_off         = r_off;
        n_size        = r_size;
        n_digits_done = r_digits_done;
        n_first_nz    = r_first_nz;
        n_magic_ok    = r_magic_ok;
        n_type        = r_type;
        n_strip       = r_strip;
        n_stripping   = r_stripping;
        n_left        = r_left;
        n_fwd         = r_fwd;
        data_done     = 1'b0;

        n_res     = 1'b0;
        n_kind    = uahw_pkg::KIND_ENTRY;
        n_etype   = uahw_pkg::ETYPE_OTHER;
        n_esize   = '0;
        n_skip    = '0;
        n_kept    = 1'b0;
        n_payload = '0;
        n_eof     = 1'b0;

        // A new header starts with fresh scan state.
        strip_on   = (r_off == '0) ? 1'b1 : r_stripping;
        strip_base = (r_off == '0) ? '0 : r_strip;
        magic_base = (r_off == '0) ? 1'b1 : r_magic_ok;

        if (r_phase == uahw_pkg::PH_HEADER) begin
            if (r_off == '0) begin
                n_size        = '0;
                n_digits_done = 1'b0;
                n_type        = '0;
                n_first_nz    = (r_data != '0);
            end
            n_strip     = strip_base;
            n_stripping = strip_on;
            n_magic_ok  = magic_base;

            // Leading run of dots and slashes in the name field.
            if (r_off < uahw_pkg::OFF_NAME_END && strip_on) begin
                if (r_data == uahw_pkg::CHAR_DOT || r_data == uahw_pkg::CHAR_SLASH) begin
                    if (strip_base < uahw_pkg::STRIP_MAX) begin
                        n_strip = strip_base + 1'b1;
                    end
                end else begin
                    n_stripping = 1'b0;
                end
            end

            // Octal size digits, up to the first non-octal byte.
            if (r_off >= uahw_pkg::OFF_SIZE_LO && r_off <= uahw_pkg::OFF_SIZE_HI
                    && !r_digits_done) begin
                if (is_octal) begin
                    n_size = {r_size[uahw_pkg::SIZE_W-4:0], r_data[2:0]};
                end else begin
                    n_digits_done = 1'b1;
                end
            end

            if (r_off == uahw_pkg::OFF_TYPE) begin
                n_type = r_data;
            end

            if (r_off >= uahw_pkg::OFF_MAGIC_LO && r_off <= uahw_pkg::OFF_MAGIC_HI
                    && r_data != uahw_pkg::magic_char(magic_idx[2:0])) begin
                n_magic_ok = 1'b0;
            end

            n_off = r_off + 1'b1;

            // Last header byte: report the entry or the end of the archive.
            if (hdr_end) begin
                n_res = 1'b1;
                if (hdr_ok) begin
                    n_kind  = uahw_pkg::KIND_ENTRY;
                    n_etype = etype;
                    n_esize = r_size;
                    n_skip  = r_strip;
                    n_kept  = (etype == uahw_pkg::ETYPE_FILE) && (r_size != '0) && size_fits;
                    n_left  = r_size;
                    n_fwd   = n_kept;
                end else begin
                    n_kind = uahw_pkg::KIND_END;
                end
            end
        end else if (r_phase == uahw_pkg::PH_DATA) begin
            if (r_left != '0) begin
                if (r_fwd) begin
                    n_res     = 1'b1;
                    n_kind    = uahw_pkg::KIND_DATA;
                    n_payload = r_data;
                    n_eof     = (r_left == uahw_pkg::SIZE_W'(1));
                end
                n_left = r_left - 1'b1;
            end
            n_off = r_off + 1'b1;
            if (n_left == '0 && n_off == '0) begin
                data_done = 1'b1;
                n_fwd     = 1'b0;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_data <= uahw_pkg::MAX_DATA_RST;
        end else if (i_cfg_wr_en) begin
            r_max_data <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data <= i_in.data_in;
            r_last <= i_in.last_in;
        end
    end

    // Walk state; the marked last byte sends the walker back to its start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_last)) begin
            r_phase       <= uahw_pkg::PH_HEADER;
            r_off         <= '0;
            r_size        <= '0;
            r_digits_done <= 1'b0;
            r_first_nz    <= 1'b0;
            r_magic_ok    <= 1'b0;
            r_type        <= '0;
            r_strip       <= '0;
            r_stripping   <= 1'b1;
            r_left        <= '0;
            r_fwd         <= 1'b0;
        end else if (proc) begin
            r_phase       <= n_phase;
            r_off         <= n_off;
            r_size        <= n_size;
            r_digits_done <= n_digits_done;
            r_first_nz    <= n_first_nz;
            r_magic_ok    <= n_magic_ok;
            r_type        <= n_type;
            r_strip       <= n_strip;
            r_stripping   <= n_stripping;
            r_left        <= n_left;
            r_fwd         <= n_fwd;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc && n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_res) begin
            r_kind    <= n_kind;
            r_etype   <= n_etype;
            r_esize   <= n_esize;
            r_skip    <= n_skip;
            r_kept    <= n_kept;
            r_payload <= n_payload;
            r_eof     <= n_eof;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.entry_type  = r_etype;
    assign o_out.entry_size  = r_esize;
    assign o_out.name_skip   = r_skip;
    assign o_out.data_kept   = r_kept;
    assign o_out.payload     = r_payload;
    assign o_out.end_of_file = r_eof;

endmodule

// ===== tb/tb_ustar_archive_header_walker.sv =====
`timescale 1ns / 1ps

module tb_ustar_archive_header_walker;
    import uahw_pkg::*;

    localparam int  BLOCK_BYTES   = 512;
    localparam int  SIZE_DIGITS   = 12;
    localparam int  BODY_MAX      = 4096;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  HOLD_CYCLES   = 1500;
    localparam int  CYCLE_LIMIT   = 2000000;
    localparam int  ERR_SHOWN     = 40;

    // Ways a generated header can be broken.
    localparam int  FAULT_NONE  = 0;
    localparam int  FAULT_LEAD  = 1;
    localparam int  FAULT_MAGIC = 2;

    // Stream layout of the run.
    localparam int  FILE_SIZE   = 200;
    localparam int  PART_BYTES  = 100;
    localparam int  JUNK_BYTES  = 40;

    localparam logic [DATA_W-1:0] DIGIT_LO   = 8'h30;
    localparam logic [DATA_W-1:0] DIGIT_HI   = 8'h37;
    localparam logic [39:0]       USTAR_TEXT = "ustar";

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              tail;
    } arch_word_t;

    typedef struct {
        t_kind             kind;
        t_etype            entry_type;
        logic [SIZE_W-1:0] entry_size;
        logic [SKIP_W-1:0] name_skip;
        logic              data_kept;
        logic [DATA_W-1:0] payload;
        logic              end_of_file;
    } arch_record_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [MAX_W-1:0]  cfg_wr_data = '0;

    uahw_in_if  in_bus ();
    uahw_out_if out_bus ();

    ustar_archive_header_walker u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    // Archive bytes waiting to be offered and records waiting to be seen.
    arch_word_t   pending_bytes[$];
    arch_record_t expected_records[$];

    int  bytes_offered = 0;
    int  bytes_taken = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic receiver_hold = 1'b0;

    // Walker state as the testbench tracks it.
    t_phase            walk_phase;
    logic [OFFSET_W-1:0] hdr_pos;
    logic [SIZE_W-1:0] size_sum;
    logic              size_closed;
    logic              lead_nonzero;
    logic              magic_good;
    logic [DATA_W-1:0] type_char;
    logic [SKIP_W-1:0] skip_count;
    logic              skip_open;
    logic [SIZE_W-1:0] body_left;
    logic              body_forward;
    logic [MAX_W-1:0]  data_limit;

    always #4 clk = ~clk;

    function automatic void restart_walk();
        walk_phase   = PH_HEADER;
        hdr_pos      = '0;
        size_sum     = '0;
        size_closed  = 1'b0;
        lead_nonzero = 1'b0;
        magic_good   = 1'b0;
        type_char    = '0;
        skip_count   = '0;
        skip_open    = 1'b1;
        body_left    = '0;
        body_forward = 1'b0;
    endfunction

    // Advance the tracked walker by one archive byte and queue any record it yields.
    function automatic void walk_byte(input logic [DATA_W-1:0] b, input logic tail);
        arch_record_t rec;
        bit           emit;
        int           idx;
        emit            = 1'b0;
        rec.kind        = KIND_ENTRY;
        rec.entry_type  = ETYPE_OTHER;
        rec.entry_size  = '0;
        rec.name_skip   = '0;
        rec.data_kept   = 1'b0;
        rec.payload     = '0;
        rec.end_of_file = 1'b0;
        case (walk_phase)
            PH_HEADER: begin
                if (hdr_pos == '0) begin
                    size_sum     = '0;
                    size_closed  = 1'b0;
                    magic_good   = 1'b1;
                    type_char    = '0;
                    skip_count   = '0;
                    skip_open    = 1'b1;
                    lead_nonzero = (b != '0);
                end
                // Leading run of dots and slashes in the name field.
                if (hdr_pos < OFF_NAME_END && skip_open) begin
                    if (b == CHAR_DOT || b == CHAR_SLASH) begin
                        if (skip_count < STRIP_MAX)
                            skip_count = skip_count + 1'b1;
                    end else begin
                        skip_open = 1'b0;
                    end
                end
                // Octal size digits until the first non-octal byte.
                if (hdr_pos >= OFF_SIZE_LO && hdr_pos <= OFF_SIZE_HI && !size_closed) begin
                    if (b >= DIGIT_LO && b <= DIGIT_HI)
                        size_sum = {size_sum[SIZE_W-4:0], b[2:0]};
                    else
                        size_closed = 1'b1;
                end
                if (hdr_pos == OFF_TYPE)
                    type_char = b;
                if (hdr_pos >= OFF_MAGIC_LO && hdr_pos <= OFF_MAGIC_HI) begin
                    idx = int'(hdr_pos) - int'(OFF_MAGIC_LO);
                    if (b != USTAR_TEXT[8*(4-idx) +: 8])
                        magic_good = 1'b0;
                end
                if (hdr_pos == OFF_LAST) begin
                    if (lead_nonzero && magic_good) begin
                        rec.entry_type = (type_char == CHAR_DIR)  ? ETYPE_DIR :
                                         (type_char == CHAR_FILE) ? ETYPE_FILE : ETYPE_OTHER;
                        rec.entry_size = size_sum;
                        rec.name_skip  = skip_count;
                        rec.data_kept  = (rec.entry_type == ETYPE_FILE) && (size_sum != '0)
                                         && (size_sum <= data_limit);
                        body_left      = size_sum;
                        body_forward   = rec.data_kept;
                        walk_phase     = (size_sum != '0) ? PH_DATA : PH_HEADER;
                    end else begin
                        rec.kind   = KIND_END;
                        walk_phase = PH_STOP;
                    end
                    emit    = 1'b1;
                    hdr_pos = '0;
                end else begin
                    hdr_pos = hdr_pos + 1'b1;
                end
            end
            PH_DATA: begin
                if (body_left != '0) begin
                    if (body_forward) begin
                        rec.kind        = KIND_DATA;
                        rec.payload     = b;
                        rec.end_of_file = (body_left == SIZE_W'(1));
                        emit            = 1'b1;
                    end
                    body_left = body_left - 1'b1;
                end
                hdr_pos = hdr_pos + 1'b1;
                if (body_left == '0 && hdr_pos == '0) begin
                    walk_phase   = PH_HEADER;
                    body_forward = 1'b0;
                end
            end
            default: ;
        endcase
        if (emit)
            expected_records.push_back(rec);
        if (tail)
            restart_walk();
    endfunction

    function automatic void check_field(input string name, input logic [SIZE_W-1:0] want,
                                        input logic [SIZE_W-1:0] got);
        if (got !== want) begin
            if (fail_count < ERR_SHOWN)
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: check the output word first, then track the accepted input word.
    always @(posedge clk) begin
        arch_record_t rec;
        if (rst_n) begin
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                if (expected_records.size() == 0) begin
                    if (fail_count < ERR_SHOWN)
                        $error("record with no expectation: kind %0h", out_bus.kind);
                    fail_count++;
                end else begin
                    rec = expected_records.pop_front();
                    check_field("kind", rec.kind, out_bus.kind);
                    check_field("entry_type", rec.entry_type, out_bus.entry_type);
                    check_field("entry_size", rec.entry_size, out_bus.entry_size);
                    check_field("name_skip", rec.name_skip, out_bus.name_skip);
                    check_field("data_kept", rec.data_kept, out_bus.data_kept);
                    check_field("payload", rec.payload, out_bus.payload);
                    check_field("end_of_file", rec.end_of_file, out_bus.end_of_file);
                end
            end
            if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
                walk_byte(in_bus.data_in, in_bus.last_in);
                bytes_taken++;
            end
        end
    end

    // Driver: offer the next word once the current one is gone, and set the receiver side.
    always @(negedge clk) begin
        if (rst_n && (!in_bus.valid || bytes_taken == bytes_offered)) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_bus.valid   <= 1'b1;
                in_bus.data_in <= pending_bytes[0].value;
                in_bus.last_in <= pending_bytes[0].tail;
                void'(pending_bytes.pop_front());
                bytes_offered++;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
        out_bus.ready <= rst_n && !receiver_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted in cycles.
    always begin
        wait (hold_req);
        receiver_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold = 1'b0;
        wait (!hold_req);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[ustar_archive_header_walker] ERROR");
            $finish;
        end
    end

    function automatic void push_byte(input logic [DATA_W-1:0] b);
        arch_word_t w;
        w.value = b;
        w.tail  = 1'b0;
        pending_bytes.push_back(w);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++)
            push_byte(DATA_W'($urandom_range(0, 255)));
    endfunction

    function automatic void mark_last();
        pending_bytes[pending_bytes.size()-1].tail = 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] rand_non_octal();
        logic [DATA_W-1:0] c;
        do
            c = DATA_W'($urandom_range(0, 255));
        while (c >= DIGIT_LO && c <= DIGIT_HI);
        return c;
    endfunction

    // A name character that ends the leading run; never NUL at byte 0.
    function automatic logic [DATA_W-1:0] rand_name_char(input bit at_start);
        logic [DATA_W-1:0] c;
        if (!at_start && $urandom_range(0, 3) == 0)
            return '0;
        do
            c = DATA_W'($urandom_range(1, 255));
        while (c == CHAR_DOT || c == CHAR_SLASH);
        return c;
    endfunction

    // Build one header block with random filler and push its first upto bytes.
    function automatic void put_header(input int dots, input logic [SIZE_W-1:0] sz,
                                       input int nd, input logic [DATA_W-1:0] term,
                                       input logic [DATA_W-1:0] tchar, input int fault,
                                       input int upto);
        logic [DATA_W-1:0] blk [BLOCK_BYTES];
        int                k;
        for (int i = 0; i < BLOCK_BYTES; i++)
            blk[i] = DATA_W'($urandom_range(0, 255));
        for (int i = 0; i < dots; i++)
            blk[i] = $urandom_range(0, 1) ? CHAR_DOT : CHAR_SLASH;
        if (dots < int'(OFF_NAME_END))
            blk[dots] = rand_name_char(dots == 0);
        for (int i = 0; i < nd; i++)
            blk[int'(OFF_SIZE_LO)+i] = DIGIT_LO | {5'b0, 3'(sz >> (3*(nd-1-i)))};
        if (nd < SIZE_DIGITS)
            blk[int'(OFF_SIZE_LO)+nd] = term;
        blk[int'(OFF_TYPE)] = tchar;
        for (int i = 0; i < 5; i++)
            blk[int'(OFF_MAGIC_LO)+i] = USTAR_TEXT[8*(4-i) +: 8];
        if (fault == FAULT_LEAD) begin
            blk[0] = '0;
        end else if (fault == FAULT_MAGIC) begin
            k = int'(OFF_MAGIC_LO) + $urandom_range(0, 4);
            blk[k] = blk[k] ^ DATA_W'($urandom_range(1, 255));
        end
        for (int i = 0; i < upto; i++)
            push_byte(blk[i]);
    endfunction

    // Body padded to blocks; a positive cut or body over BODY_MAX ends the archive early.
    function automatic void put_body(input logic [SIZE_W-1:0] sz, input int cut,
                                     output bit ended);
        longint padded;
        padded = ((longint'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
        ended  = 1'b1;
        if (cut > 0) begin
            push_random(cut);
            mark_last();
        end else if (padded <= BODY_MAX) begin
            push_random(int'(padded));
            ended = 1'b0;
        end else begin
            push_random($urandom_range(1, 700));
            mark_last();
        end
    endfunction

    // Wait for the block to go quiet, then let its pipeline settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || bytes_taken != bytes_offered ||
               expected_records.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Wait until the block has taken a given number of words.
    task automatic wait_taken(input int count);
        while (bytes_taken < count)
            @(negedge clk);
    endtask

    task automatic begin_phase(input logic [MAX_W-1:0] limit, input int idle, input int stall);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        data_limit   = limit;
        @(posedge clk);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
    endtask

    // One kept file cut at its last data byte, a partial header and a short tail,
    // with the idle mix changing as the words go through.
    initial begin
        bit gone;
        in_bus.valid   = 1'b0;
        in_bus.data_in = '0;
        in_bus.last_in = 1'b0;
        out_bus.ready  = 1'b0;
        restart_walk();
        data_limit = MAX_DATA_RST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Header of a kept file: first with no idling, then with the sender idle.
        begin_phase(16'd300, 0, 0);
        put_header(2, FILE_SIZE, 4, rand_non_octal(), CHAR_FILE, FAULT_NONE, BLOCK_BYTES);
        wait_taken(BLOCK_BYTES / 2);
        send_idle_pct = 47;

        // The sender pauses until the entry record has come out.
        wait_drained();

        // The receiver holds off while the file data streams in, so the input backs up;
        // afterwards it stalls on its own, and at the end both sides idle.
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        hold_req       = 1'b1;
        put_body(FILE_SIZE, FILE_SIZE, gone);
        put_header(3, 7, 1, " ", CHAR_FILE, FAULT_NONE, PART_BYTES);
        mark_last();
        push_random(JUNK_BYTES);
        mark_last();
        wait_taken(BLOCK_BYTES + FILE_SIZE / 2);
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        wait_drained();
        hold_req = 1'b0;

        if (fail_count == 0)
            $display("[ustar_archive_header_walker] OK");
        else
            $display("[ustar_archive_header_walker] ERROR");
        $finish;
    end

endmodule

// ===== ustar_archive_header_walker.f =====
hdl/uahw_pkg.sv
hdl/uahw_in_if.sv
hdl/uahw_out_if.sv
hdl/ustar_archive_header_walker.sv
tb/tb_ustar_archive_header_walker.sv
